// ===== rtl/sncp_pkg.sv =====
// ----------------------------------------------------------------------------
// sncp_pkg
// Shared types and constants for the surface normal cross product block.
// ----------------------------------------------------------------------------
package sncp_pkg;

  localparam int COORD_W  = 20;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int NORMAL_W = 44;
  localparam int POS_W    = 9;
  localparam int CFG_W    = 10;

  localparam int MIN_DIM   = 4;
  localparam int MAX_ROWS  = 512;
  localparam int CFG_RESET = 128;

  localparam int DEF_MAX_COLS      = 512;
  localparam int DEF_NEIGHBOR_STEP = 3;

  typedef enum logic [0:0] {
    REG_IMAGE_COLS = 1'b0,
    REG_IMAGE_ROWS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic [POS_W-1:0]           normal_row;
    logic [POS_W-1:0]           normal_col;
  } result_t;

  // position of the pixel whose normal falls due with the current point
  typedef struct packed {
    logic             due;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

endpackage

// ===== rtl/sncp_addr_gen.sv =====
// ----------------------------------------------------------------------------
// sncp_addr_gen
// Raster position counters, line store addressing and normal due decision.
// ----------------------------------------------------------------------------
module sncp_addr_gen import sncp_pkg::*; #(
  parameter int MAX_COLS      = DEF_MAX_COLS,
  parameter int NEIGHBOR_STEP = DEF_NEIGHBOR_STEP
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          accept,
  input  logic                                          frame_start,
  input  logic [CFG_W-1:0]                              image_cols,
  input  logic [CFG_W-1:0]                              image_rows,
  output logic [$clog2(NEIGHBOR_STEP * MAX_COLS)-1:0]   here_addr,
  output logic [$clog2(NEIGHBOR_STEP * MAX_COLS)-1:0]   nbr_addr,
  output pos_t                                          pos
);

  localparam int DEPTH  = NEIGHBOR_STEP * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int LIM_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int SLOT_W = (NEIGHBOR_STEP > 1) ? $clog2(NEIGHBOR_STEP) : 1;
  localparam int ROW_W  = CFG_W;

  logic [POS_W-1:0]  row_count, row_count_next;
  logic [COL_W-1:0]  col_count, col_count_next;
  logic [SLOT_W-1:0] slot, slot_next;

  logic [LIM_W-1:0]  cols;
  logic [ROW_W-1:0]  rows;
  logic [COL_W-1:0]  c_cur;
  logic [ROW_W-1:0]  r_cur, r_adv;
  logic [SLOT_W-1:0] s_cur, s_adv;
  logic [LIM_W-1:0]  c_inc;
  logic              due;

  always_comb begin
    // saturate the configured dimensions into their usable ranges
    if (image_cols < CFG_W'(MIN_DIM)) begin
      cols = LIM_W'(MIN_DIM);
    end else if (LIM_W'(image_cols) > LIM_W'(MAX_COLS)) begin
      cols = LIM_W'(MAX_COLS);
    end else begin
      cols = LIM_W'(image_cols);
    end
    if (image_rows < CFG_W'(MIN_DIM)) begin
      rows = ROW_W'(MIN_DIM);
    end else if (image_rows > CFG_W'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = image_rows;
    end

    // position this point takes
    c_cur = frame_start ? '0 : col_count;
    r_cur = frame_start ? '0 : ROW_W'(row_count);
    s_cur = frame_start ? '0 : slot;
    if (LIM_W'(c_cur) >= cols) begin
      c_cur = '0;
      r_cur = r_cur + ROW_W'(1);
      s_cur = (s_cur == SLOT_W'(NEIGHBOR_STEP - 1)) ? '0 : s_cur + SLOT_W'(1);
    end
    if (r_cur >= rows) begin
      r_cur = '0;
      s_cur = '0;
    end

    due = (r_cur >= ROW_W'(NEIGHBOR_STEP)) &&
          (LIM_W'(c_cur) + LIM_W'(NEIGHBOR_STEP) < cols);

    here_addr = AW'(s_cur * MAX_COLS) + AW'(c_cur);
    nbr_addr  = due ? here_addr + AW'(NEIGHBOR_STEP) : here_addr;

    pos.due = due;
    pos.row = POS_W'(r_cur - ROW_W'(NEIGHBOR_STEP));
    pos.col = POS_W'(c_cur);

    // position of the following point
    c_inc = LIM_W'(c_cur) + LIM_W'(1);
    r_adv = r_cur;
    s_adv = s_cur;
    if (c_inc >= cols) begin
      col_count_next = '0;
      r_adv = r_cur + ROW_W'(1);
      s_adv = (s_cur == SLOT_W'(NEIGHBOR_STEP - 1)) ? '0 : s_cur + SLOT_W'(1);
      if (r_adv >= rows) begin
        r_adv = '0;
        s_adv = '0;
      end
    end else begin
      col_count_next = COL_W'(c_inc);
    end
    row_count_next = POS_W'(r_adv);
    slot_next      = s_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      slot      <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      slot      <= slot_next;
    end
  end

endmodule

// ===== rtl/sncp_line_store.sv =====
// ----------------------------------------------------------------------------
// sncp_line_store
// Point memory for the last rows: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sncp_line_store import sncp_pkg::*; #(
  parameter int MAX_COLS      = DEF_MAX_COLS,
  parameter int NEIGHBOR_STEP = DEF_NEIGHBOR_STEP
) (
  input  logic                                        clk,
  input  logic                                        accept,
  input  logic [$clog2(NEIGHBOR_STEP * MAX_COLS)-1:0] here_addr,
  input  logic [$clog2(NEIGHBOR_STEP * MAX_COLS)-1:0] nbr_addr,
  input  point_t                                      wr_point,
  output point_t                                      base_point,
  output point_t                                      right_point
);

  localparam int DEPTH = NEIGHBOR_STEP * MAX_COLS;

  point_t mem [DEPTH];

  // reads see the old contents of the entry being overwritten
  always_ff @(posedge clk) begin
    if (accept) begin
      base_point      <= mem[here_addr];
      right_point     <= mem[nbr_addr];
      mem[here_addr]  <= wr_point;
    end
  end

endmodule

// ===== rtl/sncp_cross.sv =====
// ----------------------------------------------------------------------------
// sncp_cross
// Difference, product and cross term pipeline with output register.
// ----------------------------------------------------------------------------
module sncp_cross import sncp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  point_t  cur_point,
  input  pos_t    pos,
  input  point_t  base_point,
  input  point_t  right_point,
  output logic    ready,
  input  logic    normal_stall,
  output logic    normal_valid,
  output result_t normal
);

  logic   s1_valid;
  point_t s1_cur;
  pos_t   s1_pos;

  logic                     s2_valid;
  pos_t                     s2_pos;
  logic signed [PROD_W-1:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;

  logic ready_s2, ready_out;

  logic signed [DIFF_W-1:0]  x1, y1, z1, x2, y2, z2;
  logic signed [CROSS_W-1:0] cx, cy, cz;

  assign ready_out = !normal_valid || !normal_stall;
  assign ready_s2  = !s2_valid || ready_out;
  assign ready     = !s1_valid || ready_s2;

  // stage 1: current point and position, line store data arrives alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_cur <= cur_point;
      s1_pos <= pos;
    end
  end

  always_comb begin
    x1 = DIFF_W'(right_point.x) - DIFF_W'(base_point.x);
    y1 = DIFF_W'(right_point.y) - DIFF_W'(base_point.y);
    z1 = DIFF_W'(right_point.z) - DIFF_W'(base_point.z);
    x2 = DIFF_W'(s1_cur.x) - DIFF_W'(base_point.x);
    y2 = DIFF_W'(s1_cur.y) - DIFF_W'(base_point.y);
    z2 = DIFF_W'(s1_cur.z) - DIFF_W'(base_point.z);
  end

  // stage 2: the six products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready_s2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_s2 && s1_valid) begin
      s2_pos <= s1_pos;
      m_yz   <= PROD_W'(y1) * PROD_W'(z2);
      m_zy   <= PROD_W'(z1) * PROD_W'(y2);
      m_zx   <= PROD_W'(z1) * PROD_W'(x2);
      m_xz   <= PROD_W'(x1) * PROD_W'(z2);
      m_xy   <= PROD_W'(x1) * PROD_W'(y2);
      m_yx   <= PROD_W'(y1) * PROD_W'(x2);
    end
  end

  always_comb begin
    cx = CROSS_W'(m_yz) - CROSS_W'(m_zy);
    cy = CROSS_W'(m_zx) - CROSS_W'(m_xz);
    cz = CROSS_W'(m_xy) - CROSS_W'(m_yx);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (ready_out) begin
      normal_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && s2_valid) begin
      normal.normal_x   <= NORMAL_W'(cx);
      normal.normal_y   <= NORMAL_W'(cy);
      normal.normal_z   <= NORMAL_W'(cz);
      normal.normal_row <= s2_pos.row;
      normal.normal_col <= s2_pos.col;
    end
  end

  a_load_when_ready: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("item loaded while stage 1 is blocked");

  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !ready_out |=> s2_valid && $stable(s2_pos))
    else $error("stage 2 lost its item while blocked");

  a_out_from_stage2: assert property (@(posedge clk) disable iff (rst)
    $rose(normal_valid) |-> $past(s2_valid))
    else $error("result appeared without a stage 2 item");

  a_s1_pos_due: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_pos.due)
    else $error("stage 1 holds an item with no normal due");

endmodule

// ===== rtl/surface_normal_cross_product_top.sv =====
// The point that completes a result passes stage 1, stage 2 and the output register.
// Throughput when not stalled: one point per cycle; the line store reads its two neighbors and
// writes the new point in the same cycle, and the product pipeline takes one per cycle.
// Reset clears the position counters, pipeline valids and both dimension registers
// (to 128); the line store is not cleared and holds no data until rows are written.
// ----------------------------------------------------------------------------
// surface_normal_cross_product_top
// Streams range image points and emits surface normals by cross product.
// ----------------------------------------------------------------------------
module surface_normal_cross_product_top import sncp_pkg::*; #(
  parameter int MAX_COLS      = DEF_MAX_COLS,
  parameter int NEIGHBOR_STEP = DEF_NEIGHBOR_STEP
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_stall,
  input  in_item_t         point,
  output logic             normal_valid,
  input  logic             normal_stall,
  output result_t          normal,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_e         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(NEIGHBOR_STEP * MAX_COLS);

  logic [CFG_W-1:0] image_cols, image_rows;
  logic             ready, accept;
  logic [AW-1:0]    here_addr, nbr_addr;
  pos_t             pos;
  point_t           cur_point, base_point, right_point;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= CFG_W'(CFG_RESET);
      image_rows <= CFG_W'(CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: image_cols <= cfg_data;
        REG_IMAGE_ROWS: image_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  assign point_stall = !ready;
  assign accept      = point_valid && ready;

  assign cur_point.x = point.point_x;
  assign cur_point.y = point.point_y;
  assign cur_point.z = point.point_z;

  sncp_addr_gen #(
    .MAX_COLS      (MAX_COLS),
    .NEIGHBOR_STEP (NEIGHBOR_STEP)
  ) u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (point.frame_start),
    .image_cols  (image_cols),
    .image_rows  (image_rows),
    .here_addr   (here_addr),
    .nbr_addr    (nbr_addr),
    .pos         (pos)
  );

  sncp_line_store #(
    .MAX_COLS      (MAX_COLS),
    .NEIGHBOR_STEP (NEIGHBOR_STEP)
  ) u_line_store (
    .clk         (clk),
    .accept      (accept),
    .here_addr   (here_addr),
    .nbr_addr    (nbr_addr),
    .wr_point    (cur_point),
    .base_point  (base_point),
    .right_point (right_point)
  );

  sncp_cross u_cross (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && pos.due),
    .cur_point    (cur_point),
    .pos          (pos),
    .base_point   (base_point),
    .right_point  (right_point),
    .ready        (ready),
    .normal_stall (normal_stall),
    .normal_valid (normal_valid),
    .normal       (normal)
  );

endmodule
